// ----- sv/psp_pkg.sv -----
// Shared types, character codes and flag masks for the PIR sequence stream parser.
package psp_pkg;

  localparam int unsigned CHAIN_LEN_BITS_DEF = 16;
  localparam int unsigned OUT_LEN_W          = 16;
  localparam int unsigned OUT_DATA_W         = 48;
  localparam int unsigned RES_DEPTH          = 4;
  localparam int unsigned MAX_RESULTS        = 3;
  localparam logic [7:0]  MAX_CHAINS_RST     = 8'd64;

  typedef enum logic [2:0] {
    PH_SEEK     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_TITLE    = 3'd2,
    PH_SEQ      = 3'd3,
    PH_SKIPLINE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_RESIDUE   = 2'd0,
    KIND_CHAIN_END = 2'd1,
    KIND_ENTRY_END = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_INSERT_DASHES = 1'b0,
    CFG_MAX_CHAINS    = 1'b1
  } cfg_reg_e;

  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_LPAR   = 8'h28;  // '('
  localparam logic [7:0] CH_RPAR   = 8'h29;  // ')'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CH_F      = 8'h46;  // 'F'
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [8:0] FL_FRAGMENT   = 9'h001;
  localparam logic [8:0] FL_PUNCT      = 9'h002;
  localparam logic [8:0] FL_PAREN      = 9'h004;
  localparam logic [8:0] FL_DOTINPAREN = 9'h008;
  localparam logic [8:0] FL_NONEXPJOIN = 9'h010;
  localparam logic [8:0] FL_UNKNOWNPOS = 9'h020;
  localparam logic [8:0] FL_INCOMPLETE = 9'h040;
  localparam logic [8:0] FL_TRUNCATED  = 9'h080;
  localparam logic [8:0] FL_JUXTAPOSE  = 9'h100;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            residue;
    logic [OUT_LEN_W-1:0]  chain_length;
    logic [7:0]            chain_count;
    logic [8:0]            entry_flags;
    logic                  overflow_error;
    logic                  last;
  } result_t;

  function automatic result_t mk_result(kind_e kind, logic [7:0] residue,
                                        logic [OUT_LEN_W-1:0] len, logic [7:0] cnt,
                                        logic [8:0] flags, logic err);
    result_t r;
    r.kind           = kind;
    r.residue        = residue;
    r.chain_length   = len;
    r.chain_count    = cnt;
    r.entry_flags    = flags;
    r.overflow_error = err;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// ----- sv/pir_sequence_stream_parser_top.sv -----
// PIR sequence stream parser: per-byte parse step feeding a small result queue.
//
//   channel  | direction | transfer when              | payload
//   s_axis   | in        | s_axis_tvalid & tready     | tdata: byte_value; tuser: end_of_file
//   m_axis   | out       | m_axis_tvalid & tready     | tdata: result fields; tuser: kind;
//            |           |                            | tlast: last
//   cfg      | in        | cfg_valid_i & cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One input byte is taken per cycle while s_axis_tready is high; its 0..3 results
// enter a 4-entry queue in the same cycle and leave one per cycle while m_axis_tready
// is high. Input is taken while the queue holds at most one result, so a single
// stalled result does not block the input side. Bytes that make three results are
// paced by the single output port. Reset clears the parser state and the queue;
// config goes to insert_dashes = 0, max_chains = 64. No clearing pass is needed.
module pir_sequence_stream_parser_top #(
  parameter int unsigned CHAIN_LENGTH_BITS = psp_pkg::CHAIN_LEN_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] byte_value
  input  logic                          s_axis_tuser,   // [0] end_of_file
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] residue, [23:8] chain_length, [31:24] chain_count,
  // [40:32] entry_flags, [41] overflow_error, [47:42] zero
  output logic [psp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import psp_pkg::*;

  localparam logic [CHAIN_LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam int unsigned QPTR_W = $clog2(RES_DEPTH);
  localparam int unsigned QCNT_W = $clog2(RES_DEPTH + 1);
  localparam logic [QCNT_W-1:0] Q_ROOM = QCNT_W'(RES_DEPTH - MAX_RESULTS);

  // configuration
  logic       dashes_q;
  logic [7:0] max_chains_q;

  // parser state
  phase_e                       phase_q, phase_d;
  logic [1:0]                   hdr_pos_q, hdr_pos_d;
  logic                         hdr_f_q, hdr_f_d;
  logic [1:0]                   line_pos_q, line_pos_d;
  logic [CHAIN_LENGTH_BITS-1:0] len_q, len_d;
  logic [7:0]                   cnt_q, cnt_d;
  logic                         paren_q, paren_d;
  logic                         held_q, held_d;
  logic [7:0]                   held_res_q, held_res_d;
  logic                         slash_q, slash_d;
  logic [8:0]                   flags_q, flags_d;

  // result queue
  result_t           queue_q [RES_DEPTH];
  logic [QPTR_W-1:0] rd_ptr_q, wr_ptr_q;
  logic [QCNT_W-1:0] q_cnt_q;

  result_t    res [MAX_RESULTS];
  logic [1:0] n_res;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       eof;
  logic       skip;
  logic       is_letter;
  logic [7:0] cnt_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (q_cnt_q <= Q_ROOM);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign c             = s_axis_tdata;
  assign eof           = s_axis_tuser;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dashes_q     <= 1'b0;
      max_chains_q <= MAX_CHAINS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_INSERT_DASHES: dashes_q     <= cfg_data_i[0];
        CFG_MAX_CHAINS:    max_chains_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse step for one byte
  always_comb begin
    phase_d    = phase_q;
    hdr_pos_d  = hdr_pos_q;
    hdr_f_d    = hdr_f_q;
    line_pos_d = line_pos_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    paren_d    = paren_q;
    held_d     = held_q;
    held_res_d = held_res_q;
    slash_d    = slash_q;
    flags_d    = flags_q;
    n_res      = 2'd0;
    skip       = 1'b0;
    cnt_inc    = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;
    is_letter  = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = mk_result(KIND_RESIDUE, 8'd0, '0, 8'd0, 9'd0, 1'b0);
    end

    if (in_fire) begin
      // resolve a pending slash: truncated or incomplete
      if (phase_q == PH_SEQ && slash_q) begin
        if (!eof && (c == CH_SPACE || c == CH_TAB || c == CH_NL)) begin
          skip = 1'b1;
        end else begin
          slash_d = 1'b0;
          if (eof || c == CH_STAR || c == CH_GT) flags_d = flags_d | FL_TRUNCATED;
          else                                   flags_d = flags_d | FL_INCOMPLETE;
        end
      end

      if (!skip) begin
        if (!eof && phase_q == PH_SEQ && c != CH_STAR && c != CH_GT) begin
          if (line_pos_q != 2'd3) line_pos_d = line_pos_q + 2'd1;
        end

        if ((eof && (phase_q == PH_SEQ || phase_q == PH_SKIPLINE)) ||
            (!eof && phase_q == PH_SEQ && c == CH_GT)) begin
          // end of entry: flush held residue, close a non-empty chain
          if (held_q) begin
            res[n_res] = mk_result(KIND_RESIDUE, held_res_q, '0, 8'd0, 9'd0, 1'b0);
            n_res      = n_res + 2'd1;
          end
          cnt_d = cnt_q;
          if (len_q != '0) begin
            res[n_res] = mk_result(KIND_CHAIN_END, 8'd0, OUT_LEN_W'(len_q), 8'd0,
                                   9'd0, 1'b0);
            n_res      = n_res + 2'd1;
            cnt_d      = cnt_inc;
          end
          res[n_res] = mk_result(KIND_ENTRY_END, 8'd0, '0, cnt_d, flags_d, 1'b0);
          n_res      = n_res + 2'd1;
          len_d      = '0;
          paren_d    = 1'b0;
          held_d     = 1'b0;
          slash_d    = 1'b0;
          hdr_pos_d  = 2'd0;
          hdr_f_d    = 1'b0;
          line_pos_d = 2'd0;
          cnt_d      = 8'd0;
          flags_d    = 9'd0;
          phase_d    = eof ? PH_SEEK : PH_HEADER;
        end else if (eof) begin
          len_d      = '0;
          paren_d    = 1'b0;
          held_d     = 1'b0;
          slash_d    = 1'b0;
          hdr_pos_d  = 2'd0;
          hdr_f_d    = 1'b0;
          line_pos_d = 2'd0;
          cnt_d      = 8'd0;
          flags_d    = 9'd0;
          phase_d    = PH_SEEK;
        end else begin
          unique case (phase_q)
            PH_HEADER: begin
              if (c == CH_NL) begin
                phase_d = PH_TITLE;
              end else begin
                if (hdr_pos_q == 2'd0 && c == CH_F) hdr_f_d = 1'b1;
                if (hdr_pos_q == 2'd2 && c == CH_SEMI && hdr_f_q) begin
                  flags_d = flags_d | FL_FRAGMENT;
                end
                if (hdr_pos_q != 2'd3) hdr_pos_d = hdr_pos_q + 2'd1;
              end
            end
            PH_TITLE, PH_SKIPLINE: begin
              if (c == CH_NL) begin
                line_pos_d = 2'd0;
                phase_d    = PH_SEQ;
              end
            end
            PH_SEQ: begin
              if (c == CH_STAR) begin
                if (held_q) begin
                  res[n_res] = mk_result(KIND_RESIDUE, held_res_q, '0, 8'd0, 9'd0, 1'b0);
                  n_res      = n_res + 2'd1;
                end
                res[n_res] = mk_result(KIND_CHAIN_END, 8'd0, OUT_LEN_W'(len_q), 8'd0,
                                       9'd0, 1'b0);
                n_res      = n_res + 2'd1;
                len_d      = '0;
                paren_d    = 1'b0;
                held_d     = 1'b0;
                slash_d    = 1'b0;
                cnt_d      = cnt_inc;
                if (cnt_inc >= max_chains_q) begin
                  // chain limit: close the entry with error and resync on '>'
                  res[n_res] = mk_result(KIND_ENTRY_END, 8'd0, '0, cnt_inc, flags_d, 1'b1);
                  n_res      = n_res + 2'd1;
                  hdr_pos_d  = 2'd0;
                  hdr_f_d    = 1'b0;
                  line_pos_d = 2'd0;
                  cnt_d      = 8'd0;
                  flags_d    = 9'd0;
                  phase_d    = PH_SEEK;
                end
              end else if (is_letter || (c == CH_DASH && dashes_q)) begin
                if (held_q) begin
                  res[n_res] = mk_result(KIND_RESIDUE, held_res_q, '0, 8'd0, 9'd0, 1'b0);
                  n_res      = n_res + 2'd1;
                end
                held_res_d = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
                held_d     = 1'b1;
                if (len_q != LEN_MAX) len_d = len_q + 1'b1;
              end else if (c == CH_SLASH) begin
                flags_d = flags_d | FL_PUNCT;
                if (len_q == '0) flags_d = flags_d | FL_TRUNCATED;
                else             slash_d = 1'b1;
              end else if (c == CH_EQ) begin
                flags_d = flags_d | FL_PUNCT | FL_JUXTAPOSE;
              end else if (c == CH_LPAR) begin
                paren_d = 1'b1;
                flags_d = flags_d | FL_PUNCT | FL_PAREN;
              end else if (c == CH_RPAR) begin
                paren_d = 1'b0;
                flags_d = flags_d | FL_PUNCT | FL_PAREN;
              end else if (c == CH_DOT) begin
                flags_d = flags_d | FL_PUNCT | (paren_q ? FL_DOTINPAREN : FL_NONEXPJOIN);
              end else if (c == CH_COMMA) begin
                flags_d = flags_d | FL_UNKNOWNPOS;
              end else if (c == CH_NL) begin
                line_pos_d = 2'd0;
              end else if (c == CH_SEMI && line_pos_d == 2'd2) begin
                // text line such as "C;": withdraw the letter before it
                if (held_q) begin
                  held_d = 1'b0;
                  if (len_q != '0 && len_q != LEN_MAX) len_d = len_q - 1'b1;
                end
                phase_d = PH_SKIPLINE;
              end
            end
            default: begin
              if (c == CH_GT) begin
                len_d      = '0;
                paren_d    = 1'b0;
                held_d     = 1'b0;
                slash_d    = 1'b0;
                hdr_pos_d  = 2'd0;
                hdr_f_d    = 1'b0;
                line_pos_d = 2'd0;
                cnt_d      = 8'd0;
                flags_d    = 9'd0;
                phase_d    = PH_HEADER;
              end else begin
                phase_d = PH_SEEK;
              end
            end
          endcase
        end
      end

      if (n_res != 2'd0) res[n_res - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEEK;
      hdr_pos_q  <= 2'd0;
      hdr_f_q    <= 1'b0;
      line_pos_q <= 2'd0;
      len_q      <= '0;
      cnt_q      <= 8'd0;
      paren_q    <= 1'b0;
      held_q     <= 1'b0;
      slash_q    <= 1'b0;
      flags_q    <= 9'd0;
    end else begin
      phase_q    <= phase_d;
      hdr_pos_q  <= hdr_pos_d;
      hdr_f_q    <= hdr_f_d;
      line_pos_q <= line_pos_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      paren_q    <= paren_d;
      held_q     <= held_d;
      slash_q    <= slash_d;
      flags_q    <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_res_q <= held_res_d;
  end

  // result queue: push up to three per transfer, pop one
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < n_res) queue_q[wr_ptr_q + QPTR_W'(k)] <= res[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      if (out_fire) rd_ptr_q <= rd_ptr_q + 1'b1;
      q_cnt_q  <= q_cnt_q + QCNT_W'(n_res) - QCNT_W'(out_fire);
    end
  end

  always_comb begin
    m_axis_tvalid = (q_cnt_q != '0);
    m_axis_tuser  = queue_q[rd_ptr_q].kind;
    m_axis_tlast  = queue_q[rd_ptr_q].last;
    m_axis_tdata  = {6'd0,
                     queue_q[rd_ptr_q].overflow_error,
                     queue_q[rd_ptr_q].entry_flags,
                     queue_q[rd_ptr_q].chain_count,
                     queue_q[rd_ptr_q].chain_length,
                     queue_q[rd_ptr_q].residue};
  end

endmodule

// ----- sv/psp_checker.sv -----
// Port-level checks for the PIR sequence stream parser, bound to the top level.
module psp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [psp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);
  import psp_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_RESIDUE || m_axis_tuser == KIND_CHAIN_END ||
                       m_axis_tuser == KIND_ENTRY_END))
    else $error("unused kind code");

  // entry summary fields only on entry end
  a_entry_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_ENTRY_END |-> m_axis_tdata[41:24] == 18'd0)
    else $error("entry fields set outside entry end");

  // an entry end always closes the results of its byte
  a_entry_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ENTRY_END |-> m_axis_tlast)
    else $error("entry end not last");

endmodule

bind pir_sequence_stream_parser_top psp_checker u_psp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
